@@ rtl/gbn_pkg.sv @@
`default_nettype none
package gbn_pkg;

   // Sizing
   localparam int MAX_WINDOW       = 32;
   localparam int SHUTDOWN_REPEATS = 10;
   localparam int SEQ_W            = 16;
   localparam int CHUNK_W          = 9;
   localparam int WIN_REG_W        = 6;
   localparam int TRIES_W          = 4;
   localparam int CSR_DATA_W       = 16;
   localparam int CSR_IDX_W        = 3;
   localparam int CNT_MAX          = (MAX_WINDOW > SHUTDOWN_REPEATS) ?
                                     MAX_WINDOW : SHUTDOWN_REPEATS;
   localparam int CNT_W            = $clog2(CNT_MAX + 1);
   // sequence counts that may reach 2^SEQ_W
   localparam int TOT_W            = SEQ_W + 1;
   // full byte offset of any packet that can go out
   localparam int OFF_W            = SEQ_W + CHUNK_W;
   localparam int DIV_CNT_W        = $clog2(TOT_W + 1);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DATA_SIZE     = 3'd0,
      CSR_CHUNK_SIZE    = 3'd1,
      CSR_WINDOW_SIZE   = 3'd2,
      CSR_MAX_TRIES     = 3'd3,
      CSR_TIMEOUT_TICKS = 3'd4
   } csr_idx_type;

   // Input kinds
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   localparam logic [3:0] ACK_TYPE_DATA = 4'd2;

   typedef enum logic {
      PKT_DATA     = 1'b0,
      PKT_SHUTDOWN = 1'b1
   } pkt_kind_type;

   typedef enum logic [1:0] {
      ST_RUNNING = 2'd0,
      ST_DONE    = 2'd1,
      ST_FAILED  = 2'd2
   } status_type;

   // Beat payloads
   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       ack_type;
      logic [SEQ_W-1:0] ack_num;
   } req_type;

   typedef struct packed {
      logic               packet_kind;
      logic [SEQ_W-1:0]   seq_num;
      logic [SEQ_W-1:0]   byte_offset;
      logic [CHUNK_W-1:0] payload_len;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   // Divider control
   typedef struct packed {
      logic               start;
      logic [TOT_W-1:0]   num;
      logic [CHUNK_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [TOT_W-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/gbn_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module gbn_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gbn_pkg::div_req_type div_req,
   output gbn_pkg::div_rsp_type      div_rsp
);

   logic [gbn_pkg::TOT_W-1:0]     quot_ff, quot_in;
   logic [gbn_pkg::CHUNK_W-1:0]   rem_ff, rem_in;
   logic [gbn_pkg::CHUNK_W-1:0]   den_ff, den_in;
   logic [gbn_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [gbn_pkg::CHUNK_W:0]     trial;
   logic                          fits;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, quot_ff[gbn_pkg::TOT_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quot_in = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = gbn_pkg::DIV_CNT_W'(gbn_pkg::TOT_W);
      end else if (cnt_ff != '0) begin
         quot_in = {quot_ff[gbn_pkg::TOT_W-2:0], fits};
         rem_in  = fits ? gbn_pkg::CHUNK_W'(trial - {1'b0, den_ff})
                        : trial[gbn_pkg::CHUNK_W-1:0];
         cnt_in  = cnt_ff - gbn_pkg::DIV_CNT_W'(1);
         done_in = (cnt_ff == gbn_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule
`default_nettype wire

@@ rtl/go_back_n_sender.sv @@
// Go-Back-N sender engine. Each request beat is a start, an acknowledgement or
// a timer tick; each response beat is one packet descriptor (data or shutdown)
// or a failure notice, and the last beat caused by a request carries last=1.
// The block takes one request at a time; req_ready is high only while the
// sequencer is idle. A start computes the packet count in a restoring divider,
// then forms the window's first byte offset, then sends the packets of the
// window (up to 32), or ten shutdown packets for an empty message. An ack or
// tick that only updates state leaves the sequencer idle; one that sends a
// window first forms its offset, and one that completes the transfer sends the
// ten shutdown packets. Packets leave one per cycle through a
// single output register as long as rsp_ready stays high. Configuration writes
// are taken at any time but belong between transfers of requests.
`default_nettype none
module go_back_n_sender (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire gbn_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output gbn_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [gbn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gbn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_RUN  = 4'b0010,
      PH_DONE = 4'b0100,
      PH_FAIL = 4'b1000
   } phase_type;

   typedef enum logic [5:0] {
      SQ_IDLE = 6'b000001,
      SQ_DIV  = 6'b000010,
      SQ_MUL  = 6'b000100,
      SQ_WIN  = 6'b001000,
      SQ_SHUT = 6'b010000,
      SQ_FAIL = 6'b100000
   } seq_state_type;

   localparam int SEQ_W = gbn_pkg::SEQ_W;
   localparam int CH_W  = gbn_pkg::CHUNK_W;
   localparam int TOT_W = gbn_pkg::TOT_W;
   localparam int OFF_W = gbn_pkg::OFF_W;
   localparam int CNT_W = gbn_pkg::CNT_W;

   // Configuration registers
   logic [SEQ_W-1:0]                 data_size_ff;
   logic [CH_W-1:0]                  chunk_size_ff;
   logic [gbn_pkg::WIN_REG_W-1:0]    window_size_ff;
   logic [gbn_pkg::TRIES_W-1:0]      max_tries_ff;
   logic [SEQ_W-1:0]                 timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_size_ff   <= SEQ_W'(20);
         chunk_size_ff  <= CH_W'(1);
         window_size_ff <= gbn_pkg::WIN_REG_W'(1);
         max_tries_ff   <= gbn_pkg::TRIES_W'(10);
         timeout_ff     <= SEQ_W'(3);
      end else if (csr_wr_en) begin
         case (csr_index)
            gbn_pkg::CSR_DATA_SIZE:     data_size_ff   <= csr_wdata;
            gbn_pkg::CSR_CHUNK_SIZE:    chunk_size_ff  <= csr_wdata[CH_W-1:0];
            gbn_pkg::CSR_WINDOW_SIZE:   window_size_ff <= csr_wdata[gbn_pkg::WIN_REG_W-1:0];
            gbn_pkg::CSR_MAX_TRIES:     max_tries_ff   <= csr_wdata[gbn_pkg::TRIES_W-1:0];
            gbn_pkg::CSR_TIMEOUT_TICKS: timeout_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective register values
   logic [CH_W-1:0]               chunk_eff;
   logic [SEQ_W-1:0]              timeout_eff;
   logic [gbn_pkg::TRIES_W-1:0]   tries_eff;
   logic [CNT_W-1:0]              window_eff;

   assign chunk_eff   = (chunk_size_ff == '0) ? CH_W'(1) : chunk_size_ff;
   assign timeout_eff = (timeout_ff == '0) ? SEQ_W'(1) : timeout_ff;
   assign tries_eff   = (max_tries_ff == '0) ? gbn_pkg::TRIES_W'(1) : max_tries_ff;

   always_comb begin
      if (window_size_ff == '0)
         window_eff = CNT_W'(1);
      else if (32'(window_size_ff) > gbn_pkg::MAX_WINDOW)
         window_eff = CNT_W'(gbn_pkg::MAX_WINDOW);
      else
         window_eff = CNT_W'(window_size_ff);
   end

   // Transfer state; acked/sent counts hold the sequence number plus one
   phase_type             phase_ff, phase_in;
   seq_state_type         sq_ff, sq_in;
   logic [TOT_W-1:0]      base_ff, base_in;
   logic [TOT_W-1:0]      acked_ff, acked_in;
   logic [TOT_W-1:0]      sent_ff, sent_in;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic [gbn_pkg::TRIES_W-1:0] retry_ff, retry_in;
   logic [SEQ_W-1:0]      timer_ff, timer_in;
   logic [TOT_W-1:0]      cur_seq_ff, cur_seq_in;
   logic [OFF_W-1:0]      cur_off_ff, cur_off_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gbn_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   gbn_pkg::div_req_type  div_req;
   gbn_pkg::div_rsp_type  div_rsp;

   gbn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Datapath helpers
   logic                  req_fire;
   logic                  out_free;
   logic [TOT_W-1:0]      ack_p1;
   logic                  ack_useful;
   logic [gbn_pkg::TRIES_W-1:0] retry_p1;
   logic [OFF_W-1:0]      base_off;
   logic [TOT_W-1:0]      seq_p1;
   logic [CNT_W-1:0]      cnt_p1;
   logic                  win_last;
   logic                  off_inside;
   logic [SEQ_W-1:0]      bytes_left;
   logic [CH_W-1:0]       pkt_len;
   logic                  shut_last;

   assign req_ready = (sq_ff == SQ_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign ack_p1     = TOT_W'(req_data.ack_num) + TOT_W'(1);
   assign ack_useful = (req_data.ack_type == gbn_pkg::ACK_TYPE_DATA) &&
                       (TOT_W'(req_data.ack_num) >= acked_ff) &&
                       (TOT_W'(req_data.ack_num) < sent_ff);
   assign retry_p1   = retry_ff + gbn_pkg::TRIES_W'(1);

   // first offset of a window; base stays below the packet count here
   assign base_off   = OFF_W'(base_ff[SEQ_W-1:0]) * OFF_W'(chunk_eff);

   assign seq_p1     = cur_seq_ff + TOT_W'(1);
   assign cnt_p1     = cnt_ff + CNT_W'(1);
   assign win_last   = (cnt_p1 == window_eff) || (seq_p1 >= total_ff);
   assign off_inside = cur_off_ff < OFF_W'(data_size_ff);
   assign bytes_left = data_size_ff - cur_off_ff[SEQ_W-1:0];
   always_comb begin
      if (!off_inside)
         pkt_len = '0;
      else if (bytes_left > SEQ_W'(chunk_eff))
         pkt_len = chunk_eff;
      else
         pkt_len = bytes_left[CH_W-1:0];
   end
   assign shut_last  = (cnt_ff == CNT_W'(gbn_pkg::SHUTDOWN_REPEATS - 1));

   // Sequencer
   always_comb begin
      phase_in     = phase_ff;
      sq_in        = sq_ff;
      base_in      = base_ff;
      acked_in     = acked_ff;
      sent_in      = sent_ff;
      total_in     = total_ff;
      retry_in     = retry_ff;
      timer_in     = timer_ff;
      cur_seq_in   = cur_seq_ff;
      cur_off_in   = cur_off_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_req.start = 1'b0;
      div_req.num   = TOT_W'(data_size_ff) + TOT_W'(chunk_eff) - TOT_W'(1);
      div_req.den   = chunk_eff;

      case (sq_ff)
         SQ_IDLE: begin
            if (req_fire) begin
               case (req_data.kind)
                  gbn_pkg::KIND_START: begin
                     div_req.start = 1'b1;
                     base_in  = '0;
                     acked_in = '0;
                     sent_in  = '0;
                     retry_in = '0;
                     phase_in = PH_RUN;
                     sq_in    = SQ_DIV;
                  end
                  gbn_pkg::KIND_ACK: begin
                     if (phase_ff == PH_RUN && ack_useful) begin
                        acked_in = ack_p1;
                        base_in  = ack_p1;
                        retry_in = '0;
                        if (ack_p1 >= total_ff) begin
                           phase_in = PH_DONE;
                           timer_in = '0;
                           cnt_in   = '0;
                           sq_in    = SQ_SHUT;
                        end else if (ack_p1 == sent_ff) begin
                           timer_in = timeout_eff;
                           sq_in    = SQ_MUL;
                        end else begin
                           timer_in = timeout_eff;
                        end
                     end
                  end
                  gbn_pkg::KIND_TICK: begin
                     if (phase_ff == PH_RUN) begin
                        if (timer_ff > SEQ_W'(1)) begin
                           timer_in = timer_ff - SEQ_W'(1);
                        end else begin
                           retry_in = retry_p1;
                           if (retry_p1 >= tries_eff) begin
                              phase_in = PH_FAIL;
                              timer_in = '0;
                              sq_in    = SQ_FAIL;
                           end else begin
                              timer_in = timeout_eff;
                              sq_in    = SQ_MUL;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         SQ_DIV: begin
            if (div_rsp.done) begin
               total_in = div_rsp.quot;
               if (div_rsp.quot == '0) begin
                  phase_in = PH_DONE;
                  timer_in = '0;
                  cnt_in   = '0;
                  sq_in    = SQ_SHUT;
               end else begin
                  timer_in = timeout_eff;
                  sq_in    = SQ_MUL;
               end
            end
         end

         SQ_MUL: begin
            cur_seq_in = base_ff;
            cur_off_in = base_off;
            cnt_in     = '0;
            sq_in      = SQ_WIN;
         end

         // one data packet per beat
         SQ_WIN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.packet_kind = gbn_pkg::PKT_DATA;
               rsp_data_in.seq_num     = cur_seq_ff[SEQ_W-1:0];
               rsp_data_in.byte_offset = cur_off_ff[SEQ_W-1:0];
               rsp_data_in.payload_len = pkt_len;
               rsp_data_in.status      = gbn_pkg::ST_RUNNING;
               rsp_data_in.last        = win_last;
               if (seq_p1 > sent_ff)
                  sent_in = seq_p1;
               cur_seq_in = seq_p1;
               cur_off_in = cur_off_ff + OFF_W'(chunk_eff);
               cnt_in     = cnt_p1;
               if (win_last)
                  sq_in = SQ_IDLE;
            end
         end

         SQ_SHUT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.packet_kind = gbn_pkg::PKT_SHUTDOWN;
               rsp_data_in.seq_num     = '0;
               rsp_data_in.byte_offset = '0;
               rsp_data_in.payload_len = '0;
               rsp_data_in.status      = gbn_pkg::ST_DONE;
               rsp_data_in.last        = shut_last;
               cnt_in                  = cnt_p1;
               if (shut_last)
                  sq_in = SQ_IDLE;
            end
         end

         SQ_FAIL: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.packet_kind = gbn_pkg::PKT_DATA;
               rsp_data_in.seq_num     = '0;
               rsp_data_in.byte_offset = '0;
               rsp_data_in.payload_len = '0;
               rsp_data_in.status      = gbn_pkg::ST_FAILED;
               rsp_data_in.last        = 1'b1;
               sq_in                   = SQ_IDLE;
            end
         end

         default: sq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sq_ff        <= SQ_IDLE;
         base_ff      <= '0;
         acked_ff     <= '0;
         sent_ff      <= '0;
         total_ff     <= '0;
         retry_ff     <= '0;
         timer_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sq_ff        <= sq_in;
         base_ff      <= base_in;
         acked_ff     <= acked_in;
         sent_ff      <= sent_in;
         total_ff     <= total_in;
         retry_ff     <= retry_in;
         timer_ff     <= timer_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_seq_ff  <= cur_seq_in;
      cur_off_ff  <= cur_off_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ tb/tb_go_back_n_sender.sv @@
`timescale 1ns / 100ps
module tb_go_back_n_sender;

   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam int         SETTLE_CYCLES = 64;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         STALL_LIMIT   = 5000;
   localparam int         PHASE_BEATS   = 22;

   typedef enum {XFER_IDLE, XFER_RUN, XFER_DONE, XFER_FAIL} xfer_phase_type;

   // DUT pins
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   gbn_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   gbn_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [gbn_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gbn_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   go_back_n_sender u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Beats waiting to go in, and packets the sender should emit
   gbn_pkg::req_type pending_beats[$];
   gbn_pkg::rsp_type expected_packets[$];
   gbn_pkg::rsp_type burst_packets[$];
   int               fail_count = 0;

   // Shadow registers
   int unsigned cfg_data_size = 20;
   int unsigned cfg_chunk     = 1;
   int unsigned cfg_window    = 1;
   int unsigned cfg_max_tries = 10;
   int unsigned cfg_timeout   = 3;

   // Shadow transfer state
   xfer_phase_type xfer_phase = XFER_IDLE;
   int unsigned    win_base   = 0;
   int             hi_acked   = -1;
   int             hi_sent    = -1;
   int unsigned    pkt_total  = 0;
   logic [3:0]     retries    = '0;
   int unsigned    timer_left = 0;

   function automatic int unsigned eff_chunk();
      return (cfg_chunk == 0) ? 1 : cfg_chunk;
   endfunction

   function automatic int unsigned eff_timeout();
      return (cfg_timeout == 0) ? 1 : cfg_timeout;
   endfunction

   function automatic void add_packet(gbn_pkg::pkt_kind_type k, int unsigned seq,
                                      int unsigned off, int unsigned len,
                                      gbn_pkg::status_type st);
      gbn_pkg::rsp_type pkt;
      pkt.packet_kind = k;
      pkt.seq_num     = seq[gbn_pkg::SEQ_W-1:0];
      pkt.byte_offset = off[gbn_pkg::SEQ_W-1:0];
      pkt.payload_len = len[gbn_pkg::CHUNK_W-1:0];
      pkt.status      = st;
      pkt.last        = 1'b0;
      burst_packets.push_back(pkt);
   endfunction

   // Resend the window from the base; packets past the end are skipped
   function automatic void queue_window();
      int unsigned w, ch, seq, off, len;
      w  = (cfg_window == 0) ? 1 : cfg_window;
      if (w > gbn_pkg::MAX_WINDOW) w = gbn_pkg::MAX_WINDOW;
      ch = eff_chunk();
      for (int unsigned c = 0; c < w; c++) begin
         seq = win_base + c;
         if (seq < pkt_total) begin
            off = seq * ch;
            len = 0;
            if (off < cfg_data_size) begin
               len = cfg_data_size - off;
               if (len > ch) len = ch;
            end
            if (int'(seq) > hi_sent) hi_sent = int'(seq);
            add_packet(gbn_pkg::PKT_DATA, seq, off, len, gbn_pkg::ST_RUNNING);
         end
      end
      timer_left = eff_timeout();
   endfunction

   function automatic void queue_shutdown();
      for (int k = 0; k < gbn_pkg::SHUTDOWN_REPEATS; k++)
         add_packet(gbn_pkg::PKT_SHUTDOWN, 0, 0, 0, gbn_pkg::ST_DONE);
      xfer_phase = XFER_DONE;
      timer_left = 0;
   endfunction

   // Advance the shadow sender by one request beat
   function automatic void predict_packets(gbn_pkg::req_type beat);
      int unsigned      ch, mt, anum;
      gbn_pkg::rsp_type pkt;
      burst_packets.delete();
      anum = beat.ack_num;
      if (beat.kind == gbn_pkg::KIND_START) begin
         ch         = eff_chunk();
         pkt_total  = (cfg_data_size + ch - 1) / ch;
         win_base   = 0;
         hi_acked   = -1;
         hi_sent    = -1;
         retries    = '0;
         xfer_phase = XFER_RUN;
         if (pkt_total == 0) queue_shutdown();
         else queue_window();
      end else if (beat.kind == gbn_pkg::KIND_ACK && xfer_phase == XFER_RUN) begin
         // cumulative ack, only if it makes progress within what was sent
         if (beat.ack_type == gbn_pkg::ACK_TYPE_DATA && int'(anum) > hi_acked &&
             int'(anum) <= hi_sent) begin
            hi_acked = int'(anum);
            win_base = anum + 1;
            retries  = '0;
            if (anum + 1 >= pkt_total) queue_shutdown();
            else if (hi_acked == hi_sent) queue_window();
            else timer_left = eff_timeout();
         end
      end else if (beat.kind == gbn_pkg::KIND_TICK && xfer_phase == XFER_RUN) begin
         if (timer_left > 1) begin
            timer_left--;
         end else begin
            mt      = (cfg_max_tries == 0) ? 1 : cfg_max_tries;
            retries = retries + 4'd1;
            if (retries >= mt) begin
               xfer_phase = XFER_FAIL;
               timer_left = 0;
               add_packet(gbn_pkg::PKT_DATA, 0, 0, 0, gbn_pkg::ST_FAILED);
            end else begin
               queue_window();
            end
         end
      end
      for (int i = 0; i < burst_packets.size(); i++) begin
         pkt      = burst_packets[i];
         pkt.last = (i == burst_packets.size() - 1);
         expected_packets.push_back(pkt);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
      fail_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
   endfunction

   // Request driver: falling edge, valid held until the beat is taken
   logic req_fire = 1'b0;
   int   req_gap  = 0;

   always @(negedge clock) begin
      logic drive;
      drive = 1'b0;
      if (!reset && (!req_valid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_beats.size() > 0) begin
            drive    = 1'b1;
            req_data <= pending_beats[0];
            req_gap  = pick_gap();
         end
         req_valid <= drive;
      end
   end

   // Response ready: random stalls plus one long hold-off on request
   logic hold_wanted = 1'b0;
   logic hold_done   = 1'b0;
   int   hold_left   = 0;
   int   rsp_stall   = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
         end
      end
   end

   // Monitor: predict on request beats, check response beats in order
   always @(posedge clock) begin
      gbn_pkg::rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_packets(req_data);
            void'(pending_beats.pop_front());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_packets.size() == 0) begin
               fail_count++;
               $error("unexpected response beat");
            end else begin
               want = expected_packets.pop_front();
               if (rsp_data.packet_kind != want.packet_kind)
                  note_mismatch("packet_kind", want.packet_kind, rsp_data.packet_kind);
               if (rsp_data.seq_num != want.seq_num)
                  note_mismatch("seq_num", want.seq_num, rsp_data.seq_num);
               if (rsp_data.byte_offset != want.byte_offset)
                  note_mismatch("byte_offset", want.byte_offset, rsp_data.byte_offset);
               if (rsp_data.payload_len != want.payload_len)
                  note_mismatch("payload_len", want.payload_len, rsp_data.payload_len);
               if (rsp_data.status != want.status)
                  note_mismatch("status", want.status, rsp_data.status);
               if (rsp_data.last != want.last)
                  note_mismatch("last", want.last, rsp_data.last);
            end
         end
      end
   end

   // Watchdog on cycles without any beat or register write
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("go_back_n_sender regression: fail");
            $finish;
         end
      end
   end

   task automatic wait_cycle();
      @(posedge clock);
      #1;
   endtask

   task automatic push_beat(int unsigned kind, int unsigned atype, int unsigned num);
      gbn_pkg::req_type b;
      b.kind     = kind[1:0];
      b.ack_type = atype[3:0];
      b.ack_num  = num[gbn_pkg::SEQ_W-1:0];
      pending_beats.push_back(b);
   endtask

   // Beats the sender should drop, or plain ticks
   task automatic push_noise();
      int unsigned t;
      case ($urandom_range(0, 4))
         0: push_beat(KIND_UNUSED, $urandom_range(0, 15), $urandom_range(0, 65535));
         1: begin
            t = $urandom_range(0, 15);
            if (t == gbn_pkg::ACK_TYPE_DATA) t = 4'hF;
            push_beat(gbn_pkg::KIND_ACK, t, $urandom_range(0, 65535));
         end
         2: push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA,
                      (hi_acked >= 0) ? $urandom_range(0, hi_acked) : $urandom_range(0, 65535));
         3: push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA,
                      (hi_sent < 65535) ? $urandom_range(hi_sent + 1, 65535) : 0);
         default: push_beat(gbn_pkg::KIND_TICK, $urandom_range(0, 15),
                            $urandom_range(0, 65535));
      endcase
   endtask

   task automatic write_reg(gbn_pkg::csr_idx_type idx, int unsigned value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[gbn_pkg::CSR_DATA_W-1:0];
      case (idx)
         gbn_pkg::CSR_DATA_SIZE:     cfg_data_size = value & 16'hFFFF;
         gbn_pkg::CSR_CHUNK_SIZE:    cfg_chunk     = value & 9'h1FF;
         gbn_pkg::CSR_WINDOW_SIZE:   cfg_window    = value & 6'h3F;
         gbn_pkg::CSR_MAX_TRIES:     cfg_max_tries = value & 4'hF;
         gbn_pkg::CSR_TIMEOUT_TICKS: cfg_timeout   = value & 16'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0 || expected_packets.size() != 0) wait_cycle();
      repeat (SETTLE_CYCLES) wait_cycle();
   endtask

   // Registers change only once everything in flight has come out
   task automatic apply_settings(int unsigned ds, int unsigned cs, int unsigned ws,
                                 int unsigned mt, int unsigned tt);
      wait_drained();
      write_reg(gbn_pkg::CSR_DATA_SIZE, ds);
      write_reg(gbn_pkg::CSR_CHUNK_SIZE, cs);
      write_reg(gbn_pkg::CSR_WINDOW_SIZE, ws);
      write_reg(gbn_pkg::CSR_MAX_TRIES, mt);
      write_reg(gbn_pkg::CSR_TIMEOUT_TICKS, tt);
   endtask

   initial begin
      int          useful, n, r;
      int unsigned ds, cs, ws, mt, tt, num;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: defaults, ignored beats, ack rules, timeout, restart
      apply_settings(20, 1, 1, 10, 3);
      push_beat(KIND_UNUSED, 15, 65535);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 0);
      push_beat(gbn_pkg::KIND_TICK, 0, 0);
      push_beat(gbn_pkg::KIND_START, 0, 0);
      push_beat(gbn_pkg::KIND_ACK, 5, 0);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 1);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 0);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 0);
      repeat (3) push_beat(gbn_pkg::KIND_TICK, 0, 0);
      push_beat(gbn_pkg::KIND_START, 0, 0);

      // Empty message goes straight to shutdown; acks ignored afterward
      apply_settings(0, 511, 63, 1, 1);
      push_beat(gbn_pkg::KIND_START, 0, 0);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 0);

      // Zero registers act as one; first timeout fails the transfer
      apply_settings(1000, 0, 0, 0, 0);
      push_beat(gbn_pkg::KIND_START, 0, 0);
      push_beat(gbn_pkg::KIND_TICK, 0, 0);
      push_beat(gbn_pkg::KIND_TICK, 0, 0);

      // Short last chunk, partial ack, window-complete ack
      apply_settings(20, 3, 4, 15, 2);
      push_beat(gbn_pkg::KIND_START, 0, 0);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 1);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 3);

      // Message shrinks mid-transfer: resent packets past the end carry nothing
      apply_settings(10, 3, 4, 15, 2);
      push_beat(gbn_pkg::KIND_TICK, 0, 0);
      push_beat(gbn_pkg::KIND_TICK, 0, 0);
      push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, 6);

      // Random phases
      for (int ph = 0; ph < 6; ph++) begin
         r  = $urandom_range(0, 99);
         ds = (r < 8) ? 0 : (r < 16) ? 65535 : (r < 30) ? $urandom_range(0, 65535) :
              $urandom_range(1, 400);
         r  = $urandom_range(0, 99);
         cs = (r < 10) ? 0 : (r < 20) ? 511 : (r < 30) ? 1 : $urandom_range(1, 64);
         r  = $urandom_range(0, 99);
         ws = (r < 10) ? 0 : (r < 20) ? 63 : (r < 35) ? 32 : (r < 45) ? 1 :
              $urandom_range(1, 32);
         r  = $urandom_range(0, 99);
         mt = (r < 10) ? 0 : (r < 20) ? 1 : (r < 35) ? 15 : $urandom_range(1, 15);
         r  = $urandom_range(0, 99);
         tt = (r < 10) ? 0 : (r < 20) ? 1 : (r < 30) ? 65535 : $urandom_range(1, 5);
         if (ph == 2) begin
            // big window so the output backs up under the hold-off
            ds = 4000;
            cs = 16;
            ws = 32;
         end
         apply_settings(ds, cs, ws, mt, tt);
         if (ph == 2) hold_wanted = 1'b1;
         useful = 0;
         while (useful < PHASE_BEATS) begin
            while (pending_beats.size() != 0) wait_cycle();
            if (xfer_phase != XFER_RUN) begin
               if ($urandom_range(0, 3) == 0) push_noise();
               push_beat(gbn_pkg::KIND_START, $urandom_range(0, 15), $urandom_range(0, 65535));
               useful++;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 45 && hi_sent > hi_acked) begin
                  num = $urandom_range(0, 1) ? hi_sent : $urandom_range(hi_acked + 1, hi_sent);
                  push_beat(gbn_pkg::KIND_ACK, gbn_pkg::ACK_TYPE_DATA, num);
                  useful++;
               end else if (r < 70) begin
                  // enough ticks to expire the timer when it is short
                  n = (timer_left <= 8) ? timer_left : $urandom_range(1, 3);
                  if (n == 0) n = 1;
                  repeat (n) push_beat(gbn_pkg::KIND_TICK, $urandom_range(0, 15),
                                       $urandom_range(0, 65535));
                  useful += n;
               end else if (r < 95) begin
                  push_noise();
               end else begin
                  push_beat(gbn_pkg::KIND_START, $urandom_range(0, 15),
                            $urandom_range(0, 65535));
                  useful++;
               end
            end
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("go_back_n_sender regression: pass");
      end else begin
         $display("go_back_n_sender regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/gbn_pkg.sv
rtl/gbn_div.sv
rtl/go_back_n_sender.sv
tb/tb_go_back_n_sender.sv
